// ----- rtl/core/mmep_pkg.sv -----
// Package for the min/max envelope pyramid: payload structs, cell control
// and snapshot structs, and fixed field widths. No dependencies.
package mmep_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned LVL_W       = 5;
  localparam int unsigned IDX_W       = 23;
  localparam int unsigned CAP_LOG     = 24;
  localparam int unsigned CNT_W       = CAP_LOG + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_code;
    logic                          end_of_capture;
  } sample_in_t;

  typedef struct packed {
    logic [LVL_W-1:0]              level_number;
    logic [IDX_W-1:0]              bucket_index;
    logic signed [SAMPLE_BITS-1:0] bucket_min;
    logic signed [SAMPLE_BITS-1:0] bucket_max;
    logic                          last_of_run;
  } result_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                          load;
    logic                          take;
    logic                          eoc;
    logic                          shift;
    logic [CNT_W-1:0]              total;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cell_ctl_t;

  // Bucket snapshot handed from cell to cell toward the output.
  typedef struct packed {
    logic                          vld;
    logic signed [SAMPLE_BITS-1:0] bmin;
    logic signed [SAMPLE_BITS-1:0] bmax;
  } snap_t;

endpackage

// ----- rtl/core/mmep_cell.sv -----
// One pyramid level: running min/max of the current bucket plus a snapshot
// stage of the output chain. Depends on mmep_pkg.
module mmep_cell #(
  parameter int unsigned LEVEL = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmep_pkg::cell_ctl_t ctl_i,
  input  mmep_pkg::snap_t    nxt_i,
  output mmep_pkg::snap_t    snap_o
);
  import mmep_pkg::*;

  localparam logic [CNT_W-1:0] LowMask = (CNT_W'(1) << LEVEL) - CNT_W'(1);

  logic signed [SAMPLE_BITS-1:0] run_min_q, run_max_q;
  logic signed [SAMPLE_BITS-1:0] upd_min, upd_max;
  logic signed [SAMPLE_BITS-1:0] snap_min_q, snap_max_q;
  logic                          snap_vld_q;
  logic                          complete, fits, emit;

  always_comb begin
    upd_min  = (ctl_i.take && (ctl_i.sample < run_min_q)) ? ctl_i.sample : run_min_q;
    upd_max  = (ctl_i.take && (ctl_i.sample > run_max_q)) ? ctl_i.sample : run_max_q;
    complete = (ctl_i.total & LowMask) == '0;
    fits     = (ctl_i.total >> LEVEL) != '0;
    emit     = ctl_i.take && (complete || (ctl_i.eoc && fits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q  <= SAMPLE_MAX;
      run_max_q  <= SAMPLE_MIN;
      snap_vld_q <= 1'b0;
    end else if (ctl_i.load) begin
      run_min_q  <= (emit || ctl_i.eoc) ? SAMPLE_MAX : upd_min;
      run_max_q  <= (emit || ctl_i.eoc) ? SAMPLE_MIN : upd_max;
      snap_vld_q <= emit;
    end else if (ctl_i.shift) begin
      snap_vld_q <= nxt_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      snap_min_q <= upd_min;
      snap_max_q <= upd_max;
    end else if (ctl_i.shift) begin
      snap_min_q <= nxt_i.bmin;
      snap_max_q <= nxt_i.bmax;
    end
  end

  assign snap_o = '{vld: snap_vld_q, bmin: snap_min_q, bmax: snap_max_q};

endmodule

// ----- rtl/core/min_max_envelope_pyramid_top.sv -----
// Top level of the min/max envelope pyramid: sample counter, broadcast
// control and the row of level cells. Depends on mmep_pkg and mmep_cell.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------
//   in      | input     | in_valid_i/in_ready_o | mmep_pkg::sample_in_t
//   out     | output    | out_valid_o/out_ready_i | mmep_pkg::result_t
//
// An item that closes R buckets holds the block until its R results leave:
// all cells update in the accept cycle and latch their snapshots, then the
// snapshot chain drains toward cell 0 at one result per cycle; output stalls
// freeze the chain. The next item is taken in the cycle the last result
// leaves; an item that closes no bucket leaves the block free. Reset clears
// counter, running min/max and snapshot valid bits; no clearing pass is needed.
module min_max_envelope_pyramid_top #(
  parameter int unsigned MAX_LEVELS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mmep_pkg::sample_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mmep_pkg::result_t    out_data_o
);
  import mmep_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q;
  logic [LVL_W-1:0] level_q;
  logic             take;
  logic [CNT_W-1:0] total;
  logic             in_fire, out_fire;
  cell_ctl_t        ctl;
  snap_t            snap [MAX_LEVELS];
  snap_t            nxt  [MAX_LEVELS];

  // Samples beyond the cap are dropped; total is the count including this one.
  assign take  = !count_q[CAP_LOG];
  assign total = take ? count_q + CNT_W'(1) : count_q;

  // Emitting levels always form a prefix, so cell 0 and its neighbor tell
  // whether a result is pending and whether it is the last of the run.
  assign out_valid_o = snap[0].vld;
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !snap[0].vld || (out_ready_i && !nxt[0].vld);
  assign in_fire     = in_valid_i && in_ready_o;

  assign ctl = '{load:   in_fire,
                 take:   take,
                 eoc:    in_data_i.end_of_capture,
                 shift:  out_fire,
                 total:  total,
                 sample: in_data_i.sample_code};

  // Restart the capture after its final sample.
  assign count_d = in_data_i.end_of_capture ? '0 : total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= LVL_W'(1);
    end else if (in_fire) begin
      count_q <= count_d;
      level_q <= LVL_W'(1);
    end else if (out_fire) begin
      level_q <= level_q + LVL_W'(1);
    end
  end

  // Bucket index at level k is the pre-sample count shifted right by k, for
  // both full and flushed partial buckets; advance one shift per result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q <= count_q[IDX_W:1];
    end else if (out_fire) begin
      idx_q <= idx_q >> 1;
    end
  end

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    if (g == MAX_LEVELS - 1) begin : g_tail
      assign nxt[g] = '0;
    end else begin : g_link
      assign nxt[g] = snap[g+1];
    end
    mmep_cell #(
      .LEVEL(g + 1)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .nxt_i (nxt[g]),
      .snap_o(snap[g])
    );
  end

  assign out_data_o = '{level_number: level_q,
                        bucket_index: idx_q,
                        bucket_min:   snap[0].bmin,
                        bucket_max:   snap[0].bmax,
                        last_of_run:  !nxt[0].vld};

`ifndef SYNTHESIS
  // Pending snapshots stay a contiguous prefix of the chain.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !snap[0].vld |-> !nxt[0].vld)
    else $error("snapshot chain has a gap");

  // Reported level stays within the pyramid.
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_q != '0) && (level_q <= LVL_W'(MAX_LEVELS)))
    else $error("level out of range");

  // A final sample restarts the count.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_capture |=> count_q == '0)
    else $error("count not cleared at end of capture");
`endif

endmodule

// ----- verif/mmep_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the min/max envelope pyramid testbench: bucket predictor and
// the queue of pending bucket results. Depends on mmep_pkg.
package mmep_scoreboard_pkg;

  import mmep_pkg::*;

  localparam int unsigned PYR_LEVELS = 24;

  class envelope_scoreboard;

    logic signed [SAMPLE_BITS-1:0] bucket_lo[PYR_LEVELS];
    logic signed [SAMPLE_BITS-1:0] bucket_hi[PYR_LEVELS];
    logic [CNT_W-1:0]              samples_seen;
    result_t                       bucket_q[$];
    int unsigned                   errors;

    function new();
      errors = 0;
      restart_capture();
    endfunction

    function void restart_capture();
      for (int k = 0; k < PYR_LEVELS; k++) begin
        bucket_lo[k] = SAMPLE_MAX;
        bucket_hi[k] = SAMPLE_MIN;
      end
      samples_seen = '0;
    endfunction

    function int unsigned pending();
      return bucket_q.size();
    endfunction

    // Advance the pyramid by one accepted sample; queue the buckets it closes.
    function void note_sample(sample_in_t s);
      result_t           run[PYR_LEVELS];
      int unsigned       cnt;
      longint unsigned   n;
      longint unsigned   total;
      longint unsigned   size;
      longint unsigned   lowmask;
      bit                take;
      bit                closed;
      cnt   = 0;
      n     = samples_seen;
      take  = n < (64'd1 << CAP_LOG);
      total = take ? n + 1 : n;
      for (int k = 0; k < PYR_LEVELS; k++) begin
        size    = 64'd1 << (k + 1);
        lowmask = size - 1;
        closed  = 1'b0;
        if (take) begin
          if (s.sample_code < bucket_lo[k]) bucket_lo[k] = s.sample_code;
          if (s.sample_code > bucket_hi[k]) bucket_hi[k] = s.sample_code;
          if ((total & lowmask) == 0) begin
            run[cnt] = '{level_number: LVL_W'(k + 1), bucket_index: IDX_W'(n >> (k + 1)),
                         bucket_min: bucket_lo[k], bucket_max: bucket_hi[k],
                         last_of_run: 1'b0};
            cnt++;
            closed = 1'b1;
          end
        end
        // Flush a partial bucket at the end of a capture.
        if (!closed && s.end_of_capture && size <= total && (total & lowmask) != 0) begin
          run[cnt] = '{level_number: LVL_W'(k + 1), bucket_index: IDX_W'(total >> (k + 1)),
                       bucket_min: bucket_lo[k], bucket_max: bucket_hi[k],
                       last_of_run: 1'b0};
          cnt++;
          closed = 1'b1;
        end
        if (closed) begin
          bucket_lo[k] = SAMPLE_MAX;
          bucket_hi[k] = SAMPLE_MIN;
        end
      end
      if (s.end_of_capture) restart_capture();
      else samples_seen = CNT_W'(total);
      if (cnt > 0) run[cnt-1].last_of_run = 1'b1;
      for (int i = 0; i < cnt; i++) bucket_q.push_back(run[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (bucket_q.size() == 0) begin
        report($sformatf("unexpected result level %0d index %0d",
                         got.level_number, got.bucket_index));
      end else begin
        want = bucket_q.pop_front();
        if (got.level_number !== want.level_number)
          report($sformatf("level_number got %0d want %0d",
                           got.level_number, want.level_number));
        if (got.bucket_index !== want.bucket_index)
          report($sformatf("L%0d bucket_index got %0d want %0d",
                           want.level_number, got.bucket_index, want.bucket_index));
        if (got.bucket_min !== want.bucket_min)
          report($sformatf("L%0d/%0d bucket_min got %0d want %0d", want.level_number,
                           want.bucket_index, got.bucket_min, want.bucket_min));
        if (got.bucket_max !== want.bucket_max)
          report($sformatf("L%0d/%0d bucket_max got %0d want %0d", want.level_number,
                           want.bucket_index, got.bucket_max, want.bucket_max));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("L%0d/%0d last_of_run got %0d want %0d", want.level_number,
                           want.bucket_index, got.last_of_run, want.last_of_run));
      end
    endtask

  endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Top-level testbench for min_max_envelope_pyramid_top: directed and random
// captures with random idling on both channels. Depends on mmep_pkg and
// mmep_scoreboard_pkg.
module tb;

  import mmep_pkg::*;
  import mmep_scoreboard_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  sample_in_t in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  result_t    out_data_o;

  envelope_scoreboard sb;

  // Receiver hold-off request: set by the stimulus, served by the receiver.
  bit          hold_req;
  // When set, the sender offers items back to back.
  bit          steady;
  int unsigned random_items;

  min_max_envelope_pyramid_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor the extremes and small values near zero, otherwise any code.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return SAMPLE_MAX;
    if (r == 1) return SAMPLE_MIN;
    if (r == 2) return SAMPLE_BITS'($signed($urandom_range(0, 7)) - 4);
    return SAMPLE_BITS'($urandom);
  endfunction

  // Offer one transaction, hold it until accepted, then idle for a random gap unless steady is set.
  task send_sample(input logic signed [SAMPLE_BITS-1:0] code, input logic eoc);
    sample_in_t  item;
    int unsigned gap;
    item.sample_code    = code;
    item.end_of_capture = eoc;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(item);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send a whole capture of random samples, end flag on the last one.
  task send_capture(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Hold until the block has returned every pending bucket.
  task wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: check accepted results and drive ready with random stalls.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = idle_len();
          run_left   = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 6);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    sb           = new();
    hold_req     = 1'b0;
    steady       = 1'b0;
    random_items = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-sample capture: no level fits, so nothing comes out.
    send_sample(SAMPLE_MAX, 1'b1);
    // Two samples at opposite extremes close one level-1 bucket.
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    // Three samples: a complete level-1 bucket, then a partial flush.
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    // Eight samples end on a boundary: levels 1 to 3 complete, no flush.
    for (int i = 0; i < 8; i++)
      send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 7);
    // Five samples: partial flush at levels 1 and 2, level 3 too large.
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd400, 1'b0);
    send_sample(16'sd500, 1'b1);

    // Pause the sender until the block has emptied.
    in_valid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    // Long capture under a receiver hold-off: the block fills and stalls input.
    steady   = 1'b1;
    hold_req = 1'b1;
    send_capture($urandom_range(30, 50));
    steady = 1'b0;

    // Random captures, mostly short, a few of medium length.
    while (random_items < 90) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      steady = ($urandom_range(0, 3) == 0);
      send_capture(len);
      random_items += len;
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mmep_pkg.sv
rtl/core/mmep_cell.sv
rtl/core/min_max_envelope_pyramid_top.sv
verif/mmep_scoreboard_pkg.sv
verif/tb.sv
